### hdl/prcfd_pkg.sv
// shared types and constants for the pwm rolling code frame decoder
// no dependencies; imported by pwm_rolling_code_frame_decoder_core
`timescale 1ns / 1ps

package prcfd_pkg;

    // frame geometry
    localparam int FRAME_BITS = 64;
    localparam int PAIR_CNT_W = $clog2(FRAME_BITS + 1);

    // register reset values
    localparam logic [15:0] SHORT_TIME_RST = 16'd255;
    localparam logic [15:0] LONG_TIME_RST  = 16'd595;
    localparam logic [15:0] SHORT_TOL_RST  = 16'd150;
    localparam logic [15:0] LONG_TOL_RST   = 16'd200;

    // key field masks
    localparam logic [27:0] SERIAL_MASK = 28'h0FFFFFFF;
    localparam logic [3:0]  BUTTON_MASK = 4'hF;
    localparam logic [31:0] HALF_MASK   = 32'hFFFFFFFF;

    // configuration register indexes
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_TIME = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_TIME  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_TOL  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_TOL   = 8'd3;

    // result status codes
    typedef enum logic [1:0] {
        STATUS_FRAME  = 2'd0,
        STATUS_REJECT = 2'd1,
        STATUS_NONE   = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [16:0] duration;
        logic               last;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [27:0] serial;
        logic [3:0]  button;
        logic [31:0] hop;
        logic [63:0] key;
    } t_out_item;

    // absolute difference of two 17-bit magnitudes
    function automatic logic [16:0] abs_diff(input logic [16:0] a, input logic [16:0] b);
        logic [16:0] d;
        begin
            d = (a > b) ? (a - b) : (b - a);
            return d;
        end
    endfunction

endpackage

### hdl/pwm_rolling_code_frame_decoder_core.sv
// pwm rolling code frame decoder: pairs high/low pulses into 64 key bits
// depends on prcfd_pkg for payload types, status codes and constants
// a result appears in the output register in the cycle after its request is accepted
// throughput: one duration per cycle; the output register is the only stall point
// reset (i_rst_n low, synchronous): registers return to nominal timings, decode
// state and output valid clear
`timescale 1ns / 1ps

module pwm_rolling_code_frame_decoder_core
    import prcfd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input durations
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in,
    // results
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out,
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    // configuration registers
    logic [15:0] r_short_time, r_long_time, r_short_tol, r_long_tol;

    // decode state
    logic                  r_high_pending, n_high_pending;
    logic [15:0]           r_pend_len, n_pend_len;
    logic [FRAME_BITS-1:0] r_bit_shift, n_bit_shift;
    logic [PAIR_CNT_W-1:0] r_good_pairs, n_good_pairs;
    logic                  r_capture_done, n_capture_done;

    // output register
    logic      r_out_valid;
    t_out_item r_out, n_out;
    logic      n_emit;

    logic       in_fire;
    logic       negative, positive;
    logic [16:0] mag;
    logic [16:0] hi_ext;
    logic       is_zero, is_one;
    logic [FRAME_BITS-1:0] shifted;
    logic       frame_done;
    logic       mid_done;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // register writes, unknown indexes dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_time <= SHORT_TIME_RST;
            r_long_time  <= LONG_TIME_RST;
            r_short_tol  <= SHORT_TOL_RST;
            r_long_tol   <= LONG_TOL_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SHORT_TIME: r_short_time <= i_cfg_data;
                REG_LONG_TIME:  r_long_time  <= i_cfg_data;
                REG_SHORT_TOL:  r_short_tol  <= i_cfg_data;
                REG_LONG_TOL:   r_long_tol   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // polarity and magnitude; -65536 keeps its full magnitude
    assign negative = i_in.duration[16];
    always_comb begin
        mag      = negative ? (17'd0 - i_in.duration) : i_in.duration;
        positive = !negative && (i_in.duration != 17'sd0);
    end

    // pair classification against the configured windows
    assign hi_ext = {1'b0, r_pend_len};
    assign is_zero = (abs_diff(hi_ext, {1'b0, r_short_time}) < {1'b0, r_short_tol})
                  && (abs_diff(mag, {1'b0, r_long_time}) < {1'b0, r_long_tol});
    assign is_one  = (abs_diff(hi_ext, {1'b0, r_long_time}) < {1'b0, r_long_tol})
                  && (abs_diff(mag, {1'b0, r_short_time}) < {1'b0, r_short_tol});

    // new bit enters at the top, so the first bit ends at bit 0
    assign shifted = {!is_zero, r_bit_shift[FRAME_BITS-1:1]};

    // next decode state and result
    always_comb begin
        n_high_pending = r_high_pending;
        n_pend_len     = r_pend_len;
        n_bit_shift    = r_bit_shift;
        n_good_pairs   = r_good_pairs;
        n_capture_done = r_capture_done;
        frame_done     = 1'b0;
        n_emit         = 1'b0;
        n_out          = '0;

        if (!r_capture_done) begin
            if (!r_high_pending) begin
                if (positive) begin
                    n_high_pending = 1'b1;
                    n_pend_len     = mag[15:0];
                end else begin
                    n_bit_shift  = '0;
                    n_good_pairs = '0;
                end
            end else if (negative) begin
                n_high_pending = 1'b0;
                if (!is_zero && !is_one) begin
                    n_bit_shift  = '0;
                    n_good_pairs = '0;
                end else begin
                    n_bit_shift  = shifted;
                    n_good_pairs = r_good_pairs + PAIR_CNT_W'(1);
                    if (r_good_pairs == PAIR_CNT_W'(FRAME_BITS - 1)) begin
                        frame_done     = 1'b1;
                        n_capture_done = 1'b1;
                    end
                end
            end else begin
                n_bit_shift  = '0;
                n_good_pairs = '0;
                if (positive) begin
                    n_pend_len = mag[15:0];
                end else begin
                    n_high_pending = 1'b0;
                end
            end
        end

        mid_done = n_capture_done;

        // frame report, rejected when serial or hop is zero
        if (frame_done) begin
            n_emit = 1'b1;
            if (((shifted[27:0] & SERIAL_MASK) == 28'd0) || ((shifted[63:32] & HALF_MASK) == 32'd0)) begin
                n_out.status = STATUS_REJECT;
            end else begin
                n_out.status = STATUS_FRAME;
                n_out.serial = shifted[27:0] & SERIAL_MASK;
                n_out.button = shifted[31:28] & BUTTON_MASK;
                n_out.hop    = shifted[63:32] & HALF_MASK;
                n_out.key    = shifted;
            end
        end

        // end of capture: report a missing frame, then clear
        if (i_in.last) begin
            if (!mid_done) begin
                n_emit       = 1'b1;
                n_out        = '0;
                n_out.status = STATUS_NONE;
            end
            n_high_pending = 1'b0;
            n_pend_len     = '0;
            n_bit_shift    = '0;
            n_good_pairs   = '0;
            n_capture_done = 1'b0;
        end
    end

    // decode state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_pending <= 1'b0;
            r_pend_len     <= '0;
            r_bit_shift    <= '0;
            r_good_pairs   <= '0;
            r_capture_done <= 1'b0;
        end else if (in_fire) begin
            r_high_pending <= n_high_pending;
            r_pend_len     <= n_pend_len;
            r_bit_shift    <= n_bit_shift;
            r_good_pairs   <= n_good_pairs;
            r_capture_done <= n_capture_done;
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire && n_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (in_fire && n_emit) begin
            r_out <= n_out;
        end
    end

endmodule

### test/pwm_rolling_code_frame_decoder_core_tb.sv
// testbench for pwm_rolling_code_frame_decoder_core: directed and random pulse captures
// checked against an in-bench decoder model; depends on prcfd_pkg and the core rtl
`timescale 1ns / 1ps

module pwm_rolling_code_frame_decoder_core_tb;
    import prcfd_pkg::*;

    localparam int TIMEOUT_NS = 5_000_000;
    localparam int HOLD_CYCLES = 400;

    // bench signals; the ones the bench drives are known from time zero
    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    t_in_item             in_item = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    t_out_item            out_item;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0]          cfg_data = '0;

    // idling control
    logic steady = 1'b0;
    logic hold_armed = 1'b0;
    logic hold_fired = 1'b0;
    int   hold_left = 0;

    // register copy used by the decoder model and by the pulse generator
    logic [15:0] short_time_cfg = SHORT_TIME_RST;
    logic [15:0] long_time_cfg  = LONG_TIME_RST;
    logic [15:0] short_tol_cfg  = SHORT_TOL_RST;
    logic [15:0] long_tol_cfg   = LONG_TOL_RST;

    // decoder model state
    logic        pulse_high_pending = 1'b0;
    logic [15:0] held_high_len = '0;
    logic [63:0] key_shift = '0;
    logic [6:0]  pair_count = '0;
    logic        frame_seen = 1'b0;

    t_in_item  pending_durations [$];
    t_out_item expected_results [$];
    t_out_item want;
    int        stimulus_count = 0;
    int        mismatch_count = 0;

    pwm_rolling_code_frame_decoder_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // clock
    initial begin
        forever #5 clk = ~clk;
    end

    // run limit
    initial begin
        #(TIMEOUT_NS);
        $display("Simulation FAILED");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 50) begin
            $display("MISMATCH at %0t: %s", $time, msg);
        end
        mismatch_count++;
    endtask

    // ---------------- decoder model ----------------

    function automatic logic [17:0] gap(input logic [17:0] a, input logic [17:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // 0 or 1 for a good pair, -1 when the pair fits neither class
    function automatic int classify_pair(input logic [17:0] hi, input logic [17:0] lo);
        if (gap(hi, short_time_cfg) < short_tol_cfg && gap(lo, long_time_cfg) < long_tol_cfg)
            return 0;
        if (gap(hi, long_time_cfg) < long_tol_cfg && gap(lo, short_time_cfg) < short_tol_cfg)
            return 1;
        return -1;
    endfunction

    function automatic void drop_run();
        key_shift = '0;
        pair_count = '0;
    endfunction

    function automatic void clear_capture();
        pulse_high_pending = 1'b0;
        held_high_len = '0;
        drop_run();
        frame_seen = 1'b0;
    endfunction

    function automatic void push_result(input t_status status, input logic [63:0] key);
        t_out_item r;
        r.status = status;
        r.serial = key[27:0];
        r.button = key[31:28];
        r.hop    = key[63:32];
        r.key    = key;
        expected_results.push_back(r);
    endfunction

    // advance the model by one accepted duration
    function automatic void decode_duration(input t_in_item it);
        logic [16:0] raw;
        logic        neg;
        logic        pos;
        logic [17:0] mag;
        int          pair;
        raw = it.duration;
        neg = raw[16];
        mag = neg ? (18'h20000 - {1'b0, raw}) : {1'b0, raw};
        pos = !neg && (raw != '0);
        if (!frame_seen) begin
            if (!pulse_high_pending) begin
                if (pos) begin
                    pulse_high_pending = 1'b1;
                    held_high_len = mag[15:0];
                end else begin
                    drop_run();
                end
            end else if (neg) begin
                pair = classify_pair({2'b00, held_high_len}, mag);
                pulse_high_pending = 1'b0;
                if (pair < 0) begin
                    drop_run();
                end else begin
                    key_shift = {pair[0], key_shift[63:1]};
                    pair_count++;
                    if (pair_count >= FRAME_BITS) begin
                        if (key_shift[27:0] == '0 || key_shift[63:32] == '0)
                            push_result(STATUS_REJECT, '0);
                        else
                            push_result(STATUS_FRAME, key_shift);
                        frame_seen = 1'b1;
                    end
                end
            end else begin
                // high after high restarts the run, a zero drops the pending high
                drop_run();
                if (pos) held_high_len = mag[15:0];
                else pulse_high_pending = 1'b0;
            end
        end
        if (it.last) begin
            if (!frame_seen) push_result(STATUS_NONE, '0);
            clear_capture();
        end
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic void push_pulse(input logic [16:0] d, input bit last, input bit counted);
        t_in_item it;
        it.duration = d;
        it.last = last;
        pending_durations.push_back(it);
        if (counted) stimulus_count++;
    endfunction

    // length inside the acceptance window when it has one, boundaries now and then
    function automatic int near_length(input int nominal, input int tol, input int ceiling);
        int lo_b;
        int hi_b;
        lo_b = nominal - tol + 1;
        hi_b = nominal + tol - 1;
        if (lo_b < 1) lo_b = 1;
        if (hi_b > ceiling) hi_b = ceiling;
        if (lo_b > hi_b) return (nominal < 1) ? 1 : ((nominal > ceiling) ? ceiling : nominal);
        case ($urandom_range(0, 7))
            0: return lo_b;
            1: return hi_b;
            default: return $urandom_range(hi_b, lo_b);
        endcase
    endfunction

    function automatic logic [16:0] noise_pulse();
        int m;
        case ($urandom_range(0, 5))
            0, 1: return 17'($urandom);
            2: return '0;
            default: begin
                if ($urandom_range(0, 1) != 0)
                    m = near_length(int'(short_time_cfg), int'(short_tol_cfg), 65535);
                else
                    m = near_length(int'(long_time_cfg), int'(long_tol_cfg), 65535);
                return ($urandom_range(0, 1) != 0) ? 17'(m) : 17'(-m);
            end
        endcase
    endfunction

    // 64 high/low pairs, first pair carries key bit 0; one pulse may be corrupted
    task automatic queue_frame(input logic [63:0] key, input bit end_here, input int bad_at);
        logic [16:0] p;
        for (int i = 0; i < 2 * FRAME_BITS; i++) begin
            if (i % 2 == 0) begin
                if (key[i / 2])
                    p = 17'(near_length(int'(long_time_cfg), int'(long_tol_cfg), 65535));
                else
                    p = 17'(near_length(int'(short_time_cfg), int'(short_tol_cfg), 65535));
            end else begin
                if (key[i / 2])
                    p = 17'(-near_length(int'(short_time_cfg), int'(short_tol_cfg), 65536));
                else
                    p = 17'(-near_length(int'(long_time_cfg), int'(long_tol_cfg), 65536));
            end
            if (i == bad_at) begin
                case ($urandom_range(0, 2))
                    0: p = '0;
                    1: p = 17'(-$signed(p));
                    default: p = p[16] ? 17'(-int'($urandom_range(1, 65536)))
                                       : 17'($urandom_range(1, 65535));
                endcase
            end
            push_pulse(p, end_here && (i == 2 * FRAME_BITS - 1), 1'b1);
        end
    endtask

    task automatic random_captures(input int budget);
        int          target;
        int          kind;
        int          n;
        logic [63:0] key;
        target = stimulus_count + budget;
        while (stimulus_count < target) begin
            kind = $urandom_range(0, 99);
            key = {$urandom, $urandom};
            if (kind < 45) begin
                // well-formed frame, sometimes with zero serial or hop
                case ($urandom_range(0, 9))
                    0: key[27:0] = '0;
                    1: key[63:32] = '0;
                    default: ;
                endcase
                n = $urandom_range(0, 2);
                repeat (n) push_pulse(noise_pulse(), 1'b0, 1'b1);
                n = $urandom_range(0, 3);
                queue_frame(key, n == 0, -1);
                if (n != 0) begin
                    repeat (n - 1) push_pulse(noise_pulse(), 1'b0, 1'b0);
                    push_pulse(noise_pulse(), 1'b1, 1'b0);
                end
            end else if (kind < 65) begin
                queue_frame(key, 1'b1, $urandom_range(0, 2 * FRAME_BITS - 1));
            end else begin
                n = $urandom_range(1, 8);
                for (int i = 0; i < n; i++) push_pulse(noise_pulse(), i == n - 1, 1'b1);
            end
        end
    endtask

    // register writes plus one write to an unused index, only while idle
    task automatic program_registers(input logic [15:0] st, input logic [15:0] lt,
                                     input logic [15:0] stol, input logic [15:0] ltol);
        logic [CFG_IDX_W-1:0] idx_list [5];
        logic [15:0]          data_list [5];
        idx_list[0] = REG_SHORT_TIME;
        idx_list[1] = REG_LONG_TIME;
        idx_list[2] = REG_SHORT_TOL;
        idx_list[3] = REG_LONG_TOL;
        idx_list[4] = CFG_IDX_W'(REG_LONG_TOL + 1 + $urandom_range(0, 251));
        data_list[0] = st;
        data_list[1] = lt;
        data_list[2] = stol;
        data_list[3] = ltol;
        data_list[4] = 16'($urandom);
        for (int i = 0; i < 5; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx_list[i];
            cfg_data  <= data_list[i];
            do @(posedge clk); while (!cfg_ready);
            case (idx_list[i])
                REG_SHORT_TIME: short_time_cfg = data_list[i];
                REG_LONG_TIME:  long_time_cfg  = data_list[i];
                REG_SHORT_TOL:  short_tol_cfg  = data_list[i];
                REG_LONG_TOL:   long_tol_cfg   = data_list[i];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // wait for every request and result to clear, then idle briefly for quiet items
    task automatic settle();
        while (pending_durations.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // ---------------- driver ----------------

    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            clear_capture();
        end else begin
            if (in_valid && in_ready) decode_duration(in_item);
            if (!in_valid || in_ready) begin
                if (pending_durations.size() != 0 && (steady || $urandom_range(0, 99) >= 38)) begin
                    in_item  <= pending_durations.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor ----------------

    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            hold_left <= 0;
            hold_fired <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result, status %0d", out_item.status));
                end else begin
                    want = expected_results.pop_front();
                    if (out_item.status !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  out_item.status, want.status));
                    if (out_item.serial !== want.serial)
                        report_mismatch($sformatf("serial %h, want %h",
                                                  out_item.serial, want.serial));
                    if (out_item.button !== want.button)
                        report_mismatch($sformatf("button %h, want %h",
                                                  out_item.button, want.button));
                    if (out_item.hop !== want.hop)
                        report_mismatch($sformatf("hop %h, want %h", out_item.hop, want.hop));
                    if (out_item.key !== want.key)
                        report_mismatch($sformatf("key %h, want %h", out_item.key, want.key));
                end
            end
            // ready: one long hold-off, otherwise random stalls unless steady
            if (hold_left != 0) begin
                out_ready <= 1'b0;
                hold_left <= hold_left - 1;
            end else if (hold_armed && !hold_fired) begin
                out_ready <= 1'b0;
                hold_left <= HOLD_CYCLES;
                hold_fired <= 1'b1;
            end else begin
                out_ready <= steady || ($urandom_range(0, 99) >= 38);
            end
        end
    end

    // ---------------- stimulus ----------------

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed captures at reset timings
        // full-scale high, zero duration, full-magnitude low
        push_pulse(17'd65535, 1'b0, 1'b1);
        push_pulse('0, 1'b0, 1'b1);
        push_pulse(17'h10000, 1'b1, 1'b1);
        // low without a pending high
        push_pulse(17'(-300), 1'b1, 1'b1);
        // high after high, then a pair that fits no class
        push_pulse(17'd255, 1'b0, 1'b1);
        push_pulse(17'd800, 1'b0, 1'b1);
        push_pulse(17'(-595), 1'b1, 1'b1);
        // lone zero ending a capture
        push_pulse('0, 1'b1, 1'b1);
        // stray high then a good frame, later input ignored until last
        push_pulse(17'd2000, 1'b0, 1'b1);
        queue_frame({$urandom, $urandom} | 64'h0000_0001_0000_0001, 1'b0, -1);
        push_pulse(17'd255, 1'b0, 1'b0);
        push_pulse(17'(-595), 1'b0, 1'b0);
        push_pulse(17'(-1), 1'b1, 1'b0);
        // zero serial, frame completes on the last request
        queue_frame({$urandom, 4'($urandom), 28'h0}, 1'b1, -1);
        // zero hop, capture ends on a zero duration
        queue_frame({32'h0, $urandom}, 1'b0, -1);
        push_pulse('0, 1'b1, 1'b0);
        settle();

        // narrow timings with a long receiver hold-off
        program_registers(16'd100, 16'd300, 16'd40, 16'd60);
        random_captures(300);
        hold_armed <= 1'b1;
        settle();

        // stretch with no idling on either side
        steady <= 1'b1;
        random_captures(200);
        settle();
        steady <= 1'b0;

        // full-scale timings
        program_registers(16'd0, 16'hFFFF, 16'd1000, 16'd1000);
        random_captures(200);
        settle();

        // swapped timings, maximum tolerances
        program_registers(16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF);
        random_captures(150);
        settle();

        // zero tolerance: nothing classifies
        program_registers(SHORT_TIME_RST, LONG_TIME_RST, 16'd0, 16'd0);
        random_captures(100);
        settle();

        // back to nominal timings
        program_registers(SHORT_TIME_RST, LONG_TIME_RST, SHORT_TOL_RST, LONG_TOL_RST);
        random_captures(200);
        settle();

        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
